@@ hdl/tga_rle_pkg.sv @@
package tga_rle_pkg;

	// configuration register indexes, one 32-bit word each
	typedef enum logic {
		REG_BYTES_PER_PIXEL = 1'b0,
		REG_PIXEL_COUNT     = 1'b1
	} reg_idx_t;

	localparam int unsigned ADDR_W = 3;
	localparam int unsigned DATA_W = 32;

	// bytes per pixel code that selects the 32 bpp (B,G,R,A) layout
	localparam logic [2:0] BPP_32 = 3'd4;

	// colour byte slots
	localparam logic [1:0] IDX_BLUE  = 2'd0;
	localparam logic [1:0] IDX_GREEN = 2'd1;
	localparam logic [1:0] IDX_RED   = 2'd2;
	localparam logic [1:0] IDX_ALPHA = 2'd3;

	// reset values of the registers
	localparam logic [2:0]  BPP_RESET   = 3'd3;
	localparam logic [31:0] COUNT_RESET = 32'd1;

	// decoder status flags
	typedef struct packed {
		logic expect_header;
		logic run_packet;
		logic clamped;
		logic halted;
	} dec_flags_t;

endpackage

@@ hdl/tga_rle_pixel_decoder.sv @@
// TGA run-length pixel decoder, 24 and 32 bits per pixel.
// The input channel (in_valid/in_ready/data_byte) takes one compressed pixel
// data byte per word. Packet headers below 128 open a raw packet of header+1
// pixels, others a run of header-127 copies of one pixel. Colour bytes come
// in B,G,R(,A) order.
// The output channel (out_valid/out_ready) carries one word per raw pixel and
// one per run: red, green, blue, alpha, repeat_count, image_done and
// overflow_error. alpha is zero at 24 bpp.
// The result is registered and presented in the cycle after its last colour byte is
// accepted. Bytes are taken one per cycle while the single output register is empty
// or being drained.
// When the receiver stalls with a result waiting, in_ready drops only if the
// next byte would produce another result; header and colour bytes before it
// still flow into the state registers.
// Reset, or any APB register write, starts a new image: the decoder waits for
// a packet header. After image_done the block drops every byte until the next
// register write. APB: bytes_per_pixel at 0x0, pixel_count at 0x4.
module tga_rle_pixel_decoder (
	input  logic        clk,
	input  logic        arst_n,
	// configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [tga_rle_pkg::ADDR_W-1:0] paddr,
	input  logic [tga_rle_pkg::DATA_W-1:0] pwdata,
	output logic [tga_rle_pkg::DATA_W-1:0] prdata,
	output logic        pready,
	// byte input
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	// pixel output
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  red,
	output logic [7:0]  green,
	output logic [7:0]  blue,
	output logic [7:0]  alpha,
	output logic [7:0]  repeat_count,
	output logic        image_done,
	output logic        overflow_error
);

	logic [2:0]  bpp_q;
	logic [31:0] pixel_count_q;
	logic [31:0] remaining_q;
	logic [7:0]  packet_left_q;
	logic [1:0]  byte_index_q;
	logic [7:0]  colour_q [3];
	tga_rle_pkg::dec_flags_t flags_q, flags_d;

	logic        cfg_wr;
	logic        in_fire;
	logic        is_32;
	logic [1:0]  last_index;
	logic        last_byte;
	logic        emit;
	logic [7:0]  hdr_count;
	logic        hdr_clamp;
	logic [7:0]  px_count;
	logic [31:0] rem_next;
	logic        done_next;
	logic [7:0]  left_next;

	logic        out_valid_q;
	logic [7:0]  red_q, green_q, blue_q, alpha_q, repeat_q;
	logic        done_q, err_q;

	// apb access
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_comb begin
		unique case (tga_rle_pkg::reg_idx_t'(paddr[2]))
			tga_rle_pkg::REG_BYTES_PER_PIXEL: prdata = {29'd0, bpp_q};
			tga_rle_pkg::REG_PIXEL_COUNT:     prdata = pixel_count_q;
			default:                          prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bpp_q         <= tga_rle_pkg::BPP_RESET;
			pixel_count_q <= tga_rle_pkg::COUNT_RESET;
		end else if (cfg_wr) begin
			unique case (tga_rle_pkg::reg_idx_t'(paddr[2]))
				tga_rle_pkg::REG_BYTES_PER_PIXEL: bpp_q <= pwdata[2:0];
				tga_rle_pkg::REG_PIXEL_COUNT:     pixel_count_q <= pwdata;
				default:                          bpp_q <= bpp_q;
			endcase
		end
	end

	// byte classification
	assign is_32      = (bpp_q == tga_rle_pkg::BPP_32);
	assign last_index = is_32 ? tga_rle_pkg::IDX_ALPHA : tga_rle_pkg::IDX_RED;
	assign last_byte  = !flags_q.halted && !flags_q.expect_header &&
		(byte_index_q == last_index);

	// only a last colour byte needs room in the output register
	assign in_ready = !last_byte || !out_valid_q || out_ready;
	assign in_fire  = in_valid && in_ready;
	assign emit     = in_fire && last_byte;

	// header decode: raw h+1 and run h-127 both equal the low seven bits plus one
	assign hdr_count = {1'b0, data_byte[6:0]} + 8'd1;
	assign hdr_clamp = (remaining_q < {24'd0, hdr_count});

	// pixel accounting for a finished pixel
	assign px_count  = flags_q.run_packet ? packet_left_q : 8'd1;
	assign rem_next  = remaining_q - {24'd0, px_count};
	assign done_next = (rem_next == 32'd0);
	assign left_next = packet_left_q - px_count;

	// next decoder flags
	always_comb begin
		flags_d = flags_q;
		if (!flags_q.halted) begin
			if (flags_q.expect_header) begin
				if (remaining_q == 32'd0) begin
					flags_d.halted = 1'b1;
				end else begin
					flags_d.run_packet    = data_byte[7];
					flags_d.clamped       = hdr_clamp;
					flags_d.expect_header = 1'b0;
				end
			end else if (last_byte) begin
				if (done_next) begin
					flags_d.halted        = 1'b1;
					flags_d.expect_header = 1'b1;
				end else if (left_next == 8'd0) begin
					flags_d.expect_header = 1'b1;
					flags_d.clamped       = 1'b0;
				end
			end
		end
	end

	// decoder state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_q       <= '{expect_header: 1'b1, run_packet: 1'b0,
				clamped: 1'b0, halted: 1'b0};
			remaining_q   <= tga_rle_pkg::COUNT_RESET;
			packet_left_q <= '0;
			byte_index_q  <= '0;
		end else if (cfg_wr) begin
			flags_q       <= '{expect_header: 1'b1, run_packet: 1'b0,
				clamped: 1'b0, halted: 1'b0};
			remaining_q   <= (tga_rle_pkg::reg_idx_t'(paddr[2]) ==
				tga_rle_pkg::REG_PIXEL_COUNT) ? pwdata : pixel_count_q;
			packet_left_q <= '0;
			byte_index_q  <= '0;
		end else if (in_fire && !flags_q.halted) begin
			flags_q <= flags_d;
			if (flags_q.expect_header) begin
				packet_left_q <= hdr_clamp ? remaining_q[7:0] : hdr_count;
				byte_index_q  <= '0;
			end else if (last_byte) begin
				remaining_q   <= rem_next;
				packet_left_q <= left_next;
				byte_index_q  <= '0;
			end else begin
				byte_index_q <= byte_index_q + 2'd1;
			end
		end
	end

	// colour byte store
	always_ff @(posedge clk) begin
		if (in_fire && !flags_q.halted && !flags_q.expect_header && !last_byte &&
			!cfg_wr && (byte_index_q != tga_rle_pkg::IDX_ALPHA)) begin
			colour_q[byte_index_q] <= data_byte;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit && !cfg_wr) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit && !cfg_wr) begin
			red_q    <= is_32 ? colour_q[tga_rle_pkg::IDX_RED] : data_byte;
			green_q  <= colour_q[tga_rle_pkg::IDX_GREEN];
			blue_q   <= colour_q[tga_rle_pkg::IDX_BLUE];
			alpha_q  <= is_32 ? data_byte : 8'd0;
			repeat_q <= px_count;
			done_q   <= done_next;
			err_q    <= flags_q.clamped;
		end
	end

	assign out_valid      = out_valid_q;
	assign red            = red_q;
	assign green          = green_q;
	assign blue           = blue_q;
	assign alpha          = alpha_q;
	assign repeat_count   = repeat_q;
	assign image_done     = done_q;
	assign overflow_error = err_q;

	// colour byte position never passes the last slot of the pixel format
	a_index_range: assert property (@(posedge clk) disable iff (!arst_n)
		(byte_index_q != tga_rle_pkg::IDX_ALPHA) || is_32)
		else $error("byte index past last colour slot");

	// an open packet always has pixels left
	a_packet_open: assert property (@(posedge clk) disable iff (!arst_n)
		!flags_q.expect_header |-> (packet_left_q != 8'd0))
		else $error("open packet with no pixels left");

	// a halted decoder does not count pixels
	a_halt_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && flags_q.halted && !cfg_wr) |=> (remaining_q == $past(remaining_q)))
		else $error("pixel count moved while halted");

	// every presented result covers at least one pixel
	a_repeat_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (repeat_q != 8'd0))
		else $error("result with zero repeat count");

endmodule
